### src/uetm_pkg.sv
// ----------------------------------------------------------------------------
// uetm_pkg
// Shared types and constants for the ultrasonic echo trimmed-mean filter.
// ----------------------------------------------------------------------------
package uetm_pkg;

    // Field widths
    localparam int WIDTH_W  = 15;   // echo width, us
    localparam int SPEED_W  = 16;   // speed of sound, Q0.16
    localparam int DIST_W   = 14;   // distance, 1/16 cm
    localparam int SCNT_W   = 5;    // sample_count register
    localparam int VS_W     = 5;    // valid_samples output
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 16;

    // Product and distance
    localparam int PROD_W   = WIDTH_W + SPEED_W;
    localparam int DSHIFT   = 13;
    localparam int FDIST_W  = PROD_W - DSHIFT;

    // Trimming: drop min and max from this many accepted samples upwards
    localparam int TRIM_MIN_COUNT = 5;
    localparam int TRIM_DROP      = 2;

    localparam int MAX_BATCH_DEF  = 16;

    // Register reset values
    localparam logic [SCNT_W-1:0]  SAMPLE_COUNT_RST = 5'd5;
    localparam logic [SPEED_W-1:0] SOUND_SPEED_RST  = 16'd2248;
    localparam logic [DIST_W-1:0]  MIN_DIST_RST     = 14'd320;
    localparam logic [DIST_W-1:0]  MAX_DIST_RST     = 14'd9920;

    // Configuration register indexes
    typedef enum logic [CFG_A_W-1:0] {
        CFG_SAMPLE_COUNT = 2'd0,
        CFG_SOUND_SPEED  = 2'd1,
        CFG_MIN_DIST     = 2'd2,
        CFG_MAX_DIST     = 2'd3
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_TRIM,
        ST_DIV,
        ST_OUT
    } t_state;

    // Divider control and status
    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### src/uetm_div.sv
// ----------------------------------------------------------------------------
// uetm_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module uetm_div #(
    parameter int DVD_W = 18,
    parameter int DVS_W = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  uetm_pkg::t_div_ctrl   i_ctrl,
    input  logic [DVD_W-1:0]      i_dividend,
    input  logic [DVS_W-1:0]      i_divisor,
    output uetm_pkg::t_div_stat   o_stat,
    output logic [DVD_W-1:0]      o_quotient
);
    import uetm_pkg::*;

    localparam int ITER_W = $clog2(DVD_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic [DVS_W:0]    r_rem,  n_rem;
    logic [DVD_W-1:0]  r_quo,  n_quo;
    logic [DVS_W-1:0]  r_dvs,  n_dvs;

    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    rem_sub;
    logic              fits;

    // One shift-subtract step
    always_comb begin
        rem_sh  = {r_rem[DVS_W-1:0], r_quo[DVD_W-1]};
        fits    = (rem_sh >= {1'b0, r_dvs});
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    // Iteration control
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_iter = r_iter;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (r_busy) begin
            n_rem  = fits ? rem_sub : rem_sh;
            n_quo  = {r_quo[DVD_W-2:0], fits};
            n_iter = r_iter - ITER_W'(1);
            if (r_iter == ITER_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_ctrl.start) begin
            n_busy = 1'b1;
            n_iter = ITER_W'(DVD_W);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_iter <= n_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

### src/ultrasonic_echo_trimmed_mean.sv
// ----------------------------------------------------------------------------
// ultrasonic_echo_trimmed_mean
// Batched ultrasonic range filter with min/max trimmed mean.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall) carries one echo width per beat; 0 is a
// timeout. Each width is scaled to a distance in 1/16 cm by one multiply,
// checked against the distance window and folded into the running count,
// sum, minimum and maximum. o_stall is high while an item is in work.
// A beat that does not close a batch passes through accept, multiply and
// accumulate. The beat that closes a batch adds a trim step, then the
// shared restoring divider, one quotient bit per cycle (SUM_W quotient bits,
// 18 for the default batch depth of 16), plus a done step and a load step.
// A batch with no accepted sample skips the divider and goes from the trim
// step straight to output.
// Output channel (o_valid / i_stall) carries one result beat per batch from
// an output register; new samples are accepted while it waits. If a second
// batch finishes while the first result is still stalled, the block holds
// the new result and keeps o_stall high until the register is free.
// Synchronous reset restores the register defaults and clears the batch.
// Configuration writes (i_cfg_we) are taken in any cycle and should only be
// made while the block is idle.
// ----------------------------------------------------------------------------
module ultrasonic_echo_trimmed_mean #(
    parameter int MAX_BATCH = uetm_pkg::MAX_BATCH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [uetm_pkg::CFG_A_W-1:0]  i_cfg_addr,
    input  logic [uetm_pkg::CFG_D_W-1:0]  i_cfg_data,
    // sample channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [uetm_pkg::WIDTH_W-1:0]  i_echo_width_us,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [uetm_pkg::DIST_W-1:0]   o_mean_distance_q4,
    output logic                          o_result_valid,
    output logic [uetm_pkg::VS_W-1:0]     o_valid_samples
);
    import uetm_pkg::*;

    localparam int CNT_W = $clog2(MAX_BATCH + 1);
    localparam int SUM_W = DIST_W + $clog2(MAX_BATCH);

    // Configuration registers
    logic [SCNT_W-1:0]  r_sample_count;
    logic [SPEED_W-1:0] r_sound_speed;
    logic [DIST_W-1:0]  r_min_dist;
    logic [DIST_W-1:0]  r_max_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= SAMPLE_COUNT_RST;
            r_sound_speed  <= SOUND_SPEED_RST;
            r_min_dist     <= MIN_DIST_RST;
            r_max_dist     <= MAX_DIST_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[SCNT_W-1:0];
                CFG_SOUND_SPEED:  r_sound_speed  <= i_cfg_data[SPEED_W-1:0];
                CFG_MIN_DIST:     r_min_dist     <= i_cfg_data[DIST_W-1:0];
                CFG_MAX_DIST:     r_max_dist     <= i_cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective batch length
    logic [CNT_W-1:0] batch_len;
    always_comb begin
        if (r_sample_count == '0) begin
            batch_len = CNT_W'(1);
        end else if (int'(r_sample_count) > MAX_BATCH) begin
            batch_len = CNT_W'(MAX_BATCH);
        end else begin
            batch_len = CNT_W'(r_sample_count);
        end
    end

    // State and datapath registers
    t_state             r_state, n_state;
    logic [WIDTH_W-1:0] r_width, n_width;
    logic [PROD_W-1:0]  r_prod,  n_prod;
    logic [CNT_W-1:0]   r_pos,   n_pos;
    logic [CNT_W-1:0]   r_good,  n_good;
    logic [SUM_W-1:0]   r_sum,   n_sum;
    logic [DIST_W-1:0]  r_lo,    n_lo;
    logic [DIST_W-1:0]  r_hi,    n_hi;
    logic [DIST_W-1:0]  r_mean,  n_mean;
    logic               r_rvld,  n_rvld;
    logic               r_ovld,  n_ovld;
    logic [DIST_W-1:0]  r_omean, n_omean;
    logic               r_orv,   n_orv;
    logic [VS_W-1:0]    r_ovs,   n_ovs;

    // Divider interface
    t_div_ctrl          div_ctrl;
    t_div_stat          div_stat;
    logic [SUM_W-1:0]   div_dvd;
    logic [CNT_W-1:0]   div_dvs;
    logic [SUM_W-1:0]   div_quo;

    // Distance and window check
    logic [FDIST_W-1:0] dist_full;
    logic               in_win;
    logic [CNT_W-1:0]   pos_inc;
    logic               last_beat;
    logic               out_free;
    logic [CNT_W+VS_W-1:0] good_ext;

    always_comb begin
        dist_full = r_prod[PROD_W-1:DSHIFT];
        in_win    = (r_width != '0)
                    && (dist_full >= FDIST_W'(r_min_dist))
                    && (dist_full <= FDIST_W'(r_max_dist));
        pos_inc   = r_pos + CNT_W'(1);
        last_beat = (pos_inc >= batch_len);
        out_free  = !r_ovld || !i_stall;
        good_ext  = {{VS_W{1'b0}}, r_good};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_MUL;
            ST_MUL:  n_state = ST_ACC;
            ST_ACC:  n_state = last_beat ? ST_TRIM : ST_IDLE;
            ST_TRIM: n_state = (r_good == '0) ? ST_OUT : ST_DIV;
            ST_DIV:  if (div_stat.done) n_state = ST_OUT;
            ST_OUT:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_width  = r_width;
        n_prod   = r_prod;
        n_pos    = r_pos;
        n_good   = r_good;
        n_sum    = r_sum;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mean   = r_mean;
        n_rvld   = r_rvld;
        n_omean  = r_omean;
        n_orv    = r_orv;
        n_ovs    = r_ovs;
        n_ovld   = r_ovld && i_stall;
        div_ctrl = '0;
        div_dvd  = r_sum;
        div_dvs  = r_good;
        case (r_state)
            ST_IDLE: begin
                n_width = i_echo_width_us;
            end
            ST_MUL: begin
                n_prod = PROD_W'(r_width) * PROD_W'(r_sound_speed);
            end
            ST_ACC: begin
                n_pos = pos_inc;
                if (in_win) begin
                    n_good = r_good + CNT_W'(1);
                    n_sum  = r_sum + SUM_W'(dist_full[DIST_W-1:0]);
                    if (dist_full[DIST_W-1:0] < r_lo) n_lo = dist_full[DIST_W-1:0];
                    if (dist_full[DIST_W-1:0] > r_hi) n_hi = dist_full[DIST_W-1:0];
                end
            end
            ST_TRIM: begin
                // drop one minimum and one maximum from larger batches
                n_mean = '0;
                n_rvld = (r_good != '0);
                if (int'(r_good) >= TRIM_MIN_COUNT) begin
                    div_dvd = r_sum - SUM_W'(r_lo) - SUM_W'(r_hi);
                    div_dvs = r_good - CNT_W'(TRIM_DROP);
                end
                div_ctrl.start = (r_good != '0);
            end
            ST_DIV: begin
                if (div_stat.done) n_mean = div_quo[DIST_W-1:0];
            end
            ST_OUT: begin
                if (out_free) begin
                    n_ovld  = 1'b1;
                    n_omean = r_mean;
                    n_orv   = r_rvld;
                    n_ovs   = good_ext[VS_W-1:0];
                    // start a fresh batch
                    n_pos   = '0;
                    n_good  = '0;
                    n_sum   = '0;
                    n_lo    = '1;
                    n_hi    = '0;
                end
            end
            default: ;
        endcase
    end

    // Control and batch state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos   <= '0;
            r_good  <= '0;
            r_sum   <= '0;
            r_lo    <= '1;
            r_hi    <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_good  <= n_good;
            r_sum   <= n_sum;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_ovld  <= n_ovld;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_width <= n_width;
        r_prod  <= n_prod;
        r_mean  <= n_mean;
        r_rvld  <= n_rvld;
        r_omean <= n_omean;
        r_orv   <= n_orv;
        r_ovs   <= n_ovs;
    end

    // Shared divider
    uetm_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (div_ctrl),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    assign o_stall            = (r_state != ST_IDLE);
    assign o_valid            = r_ovld;
    assign o_mean_distance_q4 = r_omean;
    assign o_result_valid     = r_orv;
    assign o_valid_samples    = r_ovs;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: ultrasonic echo trimmed-mean filter testbench
// Drives echo widths under several register settings, predicts every batch
// result (distance scaling, window rejection, min/max trim, truncating mean)
// and checks each result beat in order, with random gaps and stalls.
// ----------------------------------------------------------------------------
import uetm_pkg::*;

// Expected result of one batch
typedef struct {
    logic [DIST_W-1:0] mean;
    logic              ok;
    logic [VS_W-1:0]   count;
} t_batch_result;

// Batch predictor and result checker
class range_filter_checker;
    // register copies
    logic [SCNT_W-1:0]  batch_len_reg;
    logic [SPEED_W-1:0] speed_q16;
    logic [DIST_W-1:0]  window_lo;
    logic [DIST_W-1:0]  window_hi;
    // batch state
    int unsigned        position;
    int unsigned        good_count;
    int unsigned        dist_sum;
    int unsigned        dist_min;
    int unsigned        dist_max;
    t_batch_result      batches_due[$];
    int                 errors;

    function new();
        batch_len_reg = SAMPLE_COUNT_RST;
        speed_q16     = SOUND_SPEED_RST;
        window_lo     = MIN_DIST_RST;
        window_hi     = MAX_DIST_RST;
        errors        = 0;
        clear_batch();
    endfunction

    function void clear_batch();
        position   = 0;
        good_count = 0;
        dist_sum   = 0;
        dist_min   = (1 << DIST_W) - 1;
        dist_max   = 0;
    endfunction

    function void write_reg(t_cfg_idx idx, logic [CFG_D_W-1:0] value);
        case (idx)
            CFG_SAMPLE_COUNT: batch_len_reg = value[SCNT_W-1:0];
            CFG_SOUND_SPEED:  speed_q16     = value[SPEED_W-1:0];
            CFG_MIN_DIST:     window_lo     = value[DIST_W-1:0];
            CFG_MAX_DIST:     window_hi     = value[DIST_W-1:0];
            default:          ;
        endcase
    endfunction

    // Fold one accepted echo into the batch; queue a result at batch end
    function void note_echo(logic [WIDTH_W-1:0] width);
        logic [PROD_W-1:0]  prod;
        logic [FDIST_W-1:0] distance;
        int unsigned        eff_len;
        int unsigned        sum;
        int unsigned        cnt;
        t_batch_result      r;
        prod = width * speed_q16;
        distance = prod[PROD_W-1:DSHIFT];
        // full-width compare, so oversized products never wrap into range
        if (width != 0 && distance >= window_lo && distance <= window_hi) begin
            good_count++;
            dist_sum += distance;
            if (distance < dist_min) dist_min = distance;
            if (distance > dist_max) dist_max = distance;
        end
        position++;
        eff_len = (batch_len_reg == 0) ? 1 :
                  (batch_len_reg > MAX_BATCH_DEF) ? MAX_BATCH_DEF : batch_len_reg;
        if (position < eff_len) return;
        r.mean  = '0;
        r.ok    = 1'b0;
        r.count = good_count[VS_W-1:0];
        if (good_count != 0) begin
            sum = dist_sum;
            cnt = good_count;
            if (cnt >= TRIM_MIN_COUNT) begin
                sum = sum - dist_min - dist_max;
                cnt = cnt - TRIM_DROP;
            end
            r.mean = (sum / cnt) & ((1 << DIST_W) - 1);
            r.ok   = 1'b1;
        end
        batches_due.push_back(r);
        clear_batch();
    endfunction

    function void check_batch(logic [DIST_W-1:0] mean, logic ok, logic [VS_W-1:0] count);
        t_batch_result exp_r;
        if (batches_due.size() == 0) begin
            $display("%0t: result beat with none due: mean %0d valid %0d samples %0d",
                     $time, mean, ok, count);
            errors++;
            return;
        end
        exp_r = batches_due.pop_front();
        if (mean !== exp_r.mean) begin
            $display("%0t: mean_distance_q4 expected %0d actual %0d",
                     $time, exp_r.mean, mean);
            errors++;
        end
        if (ok !== exp_r.ok) begin
            $display("%0t: result_valid expected %0d actual %0d", $time, exp_r.ok, ok);
            errors++;
        end
        if (count !== exp_r.count) begin
            $display("%0t: valid_samples expected %0d actual %0d",
                     $time, exp_r.count, count);
            errors++;
        end
    endfunction

    function int pending();
        return batches_due.size();
    endfunction
endclass

module tb;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS  = 180;
    localparam int NUM_PHASES   = 6;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    t_cfg_idx             i_cfg_addr = CFG_SAMPLE_COUNT;
    logic [CFG_D_W-1:0]   i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [WIDTH_W-1:0]   i_echo_width_us = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [DIST_W-1:0]    o_mean_distance_q4;
    logic                 o_result_valid;
    logic [VS_W-1:0]      o_valid_samples;

    range_filter_checker  chk = new();
    int                   gap_pct = 0;      // sender idle chance, percent
    int                   stall_pct = 0;    // receiver stall chance, percent
    int unsigned          cycles = 0;

    ultrasonic_echo_trimmed_mean #(
        .MAX_BATCH (MAX_BATCH_DEF)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_echo_width_us    (i_echo_width_us),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_mean_distance_q4 (o_mean_distance_q4),
        .o_result_valid     (o_result_valid),
        .o_valid_samples    (o_valid_samples)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: check beats taken at this edge, then pick next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            chk.check_batch(o_mean_distance_q4, o_result_valid, o_valid_samples);
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // One echo beat, with random idle cycles ahead of it
    task automatic send_echo(input logic [WIDTH_W-1:0] width);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_echo_width_us <= width;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        chk.note_echo(width);
    endtask

    // Hold the sender until all results are in, then let the block settle
    task automatic wait_results(input int settle);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_D_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        chk.write_reg(idx, value);
    endtask

    task automatic set_regs(input logic [CFG_D_W-1:0] cnt, input logic [CFG_D_W-1:0] spd,
                            input logic [CFG_D_W-1:0] lo, input logic [CFG_D_W-1:0] hi);
        write_reg(CFG_SAMPLE_COUNT, cnt);
        write_reg(CFG_SOUND_SPEED, spd);
        write_reg(CFG_MIN_DIST, lo);
        write_reg(CFG_MAX_DIST, hi);
    endtask

    // Mostly widths that land inside the window, plus timeouts and noise
    function automatic logic [WIDTH_W-1:0] pick_width();
        int                pick;
        longint unsigned   w;
        int unsigned       d;
        int unsigned       spd;
        pick = $urandom_range(0, 99);
        if (pick < 8) return '0;
        if (pick < 22) return WIDTH_W'($urandom_range(0, (1 << WIDTH_W) - 1));
        if (pick < 28) begin
            case ($urandom_range(0, 3))
                0:       return WIDTH_W'(1);
                1:       return WIDTH_W'(30000);
                2:       return WIDTH_W'((1 << WIDTH_W) - 1);
                default: return WIDTH_W'(1 << (WIDTH_W - 1));
            endcase
        end
        if (chk.window_lo <= chk.window_hi)
            d = $urandom_range(chk.window_lo, chk.window_hi);
        else
            d = $urandom_range(0, (1 << DIST_W) - 1);
        spd = (chk.speed_q16 == 0) ? 1 : chk.speed_q16;
        w = ((longint'(d) << DSHIFT) / spd) + $urandom_range(0, 1);
        if (w > (1 << WIDTH_W) - 1) w = (1 << WIDTH_W) - 1;
        return w[WIDTH_W-1:0];
    endfunction

    initial begin
        int lo;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: timeout-only (empty) batch, trimmed batch, extreme widths
        repeat (5) send_echo('0);
        send_echo(1200); send_echo(1500); send_echo(2000);
        send_echo(2500); send_echo(3000);
        send_echo(1); send_echo(15'h7FFF); send_echo(15'h4000);
        send_echo(100); send_echo(2400);
        wait_results(SETTLE_CYCLES);

        // Batch length lowered part-way through a batch
        write_reg(CFG_SAMPLE_COUNT, 10);
        repeat (7) send_echo(2000);
        wait_results(SETTLE_CYCLES);
        write_reg(CFG_SAMPLE_COUNT, 3);
        send_echo(2200);
        wait_results(SETTLE_CYCLES);

        // Inverted window rejects everything
        set_regs(1, SOUND_SPEED_RST, 5000, 4000);
        send_echo(15000);
        send_echo(2000);
        wait_results(SETTLE_CYCLES);

        // Length 0 acts as 1; full-scale product must not wrap into range
        set_regs(0, 16'hFFFF, 0, 16'h3FFF);
        send_echo(15'h7FFF);
        send_echo(2000);
        send_echo('0);
        wait_results(SETTLE_CYCLES);

        // Random phases under changing settings and idling patterns
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: set_regs(CFG_D_W'(SAMPLE_COUNT_RST), SOUND_SPEED_RST,
                            CFG_D_W'(MIN_DIST_RST), CFG_D_W'(MAX_DIST_RST));
                1: set_regs(16, 16'hFFFF, 0, 16'h3FFF);
                2: set_regs(1, 1, 0, 3);
                3: begin
                    lo = $urandom_range(0, 2000);
                    set_regs(CFG_D_W'(31), CFG_D_W'($urandom_range(1, 65535)),
                             CFG_D_W'(lo), CFG_D_W'($urandom_range(2000, 16383)));
                end
                default: set_regs(CFG_D_W'($urandom), CFG_D_W'($urandom),
                                  CFG_D_W'($urandom), CFG_D_W'($urandom));
            endcase
            case (p % 3)
                0: begin gap_pct = 22; stall_pct = 88; end
                1: begin gap_pct = 88; stall_pct = 22; end
                default: begin gap_pct = 0; stall_pct = 0; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 0 && n == PHASE_ITEMS / 2) wait_results(0);
                send_echo(pick_width());
            end
            wait_results(SETTLE_CYCLES);
        end

        if (chk.errors == 0 && chk.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
